// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent assertions
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SACU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define SACU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== src/sacu_pkg.sv =====
// ---------------------------------------------------------------------------
// sacu_pkg
// types, codes and tables of the sgr attribute and color unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sacu_pkg;

  localparam int IN_W       = 40;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREY_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREY_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_FG      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_BG      = 3'd5;

  // sgr codes
  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_BOLD      = 8'd1;
  localparam logic [7:0] SGR_ULINE     = 8'd4;
  localparam logic [7:0] SGR_REVERSE   = 8'd7;
  localparam logic [7:0] SGR_CONCEAL   = 8'd8;
  localparam logic [7:0] SGR_CROSSED   = 8'd9;
  localparam logic [7:0] SGR_NO_BOLD   = 8'd22;
  localparam logic [7:0] SGR_NO_ULINE  = 8'd24;
  localparam logic [7:0] SGR_NO_REV    = 8'd27;
  localparam logic [7:0] SGR_NO_CONC   = 8'd28;
  localparam logic [7:0] SGR_NO_CROSS  = 8'd29;
  localparam logic [7:0] SGR_FG_FIRST  = 8'd30;
  localparam logic [7:0] SGR_FG_LAST   = 8'd37;
  localparam logic [7:0] SGR_FG_EXT    = 8'd38;
  localparam logic [7:0] SGR_FG_DEF    = 8'd39;
  localparam logic [7:0] SGR_BG_FIRST  = 8'd40;
  localparam logic [7:0] SGR_BG_LAST   = 8'd47;
  localparam logic [7:0] SGR_BG_EXT    = 8'd48;
  localparam logic [7:0] SGR_BG_DEF    = 8'd49;

  // color formats
  localparam logic [7:0] FMT_RGB   = 8'd2;
  localparam logic [7:0] FMT_INDEX = 8'd5;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_CODE = 2'd1;
  localparam logic [1:0] STAT_BAD_FMT  = 2'd2;

  // reset values
  localparam logic [2:0] RST_CUBE_LEVELS = 3'd6;
  localparam logic [7:0] RST_CUBE_BASE   = 8'd16;
  localparam logic [4:0] RST_GREY_COUNT  = 5'd24;
  localparam logic [7:0] RST_GREY_BASE   = 8'd232;
  localparam logic [2:0] RST_DEF_FG      = 3'd7;
  localparam logic [7:0] RST_DEF_BG      = 8'd0;

  // reciprocal of 3 scaled by 2^11, exact for sums below 2048
  localparam logic [9:0] RECIP3 = 10'd683;

  typedef struct packed {
    logic [2:0] cube_levels;
    logic [7:0] cube_base;
    logic [4:0] grey_count;
    logic [7:0] grey_base;
  } sacu_cube_cfg_t;

  typedef struct packed {
    logic       done;
    logic [7:0] color;
  } sacu_seq_res_t;

  // 256 / cube levels, with zero taken as one
  function automatic logic [8:0] grey_limit(input logic [2:0] cs);
    logic [8:0] lim;
    case (cs)
      3'd2:    lim = 9'd128;
      3'd3:    lim = 9'd85;
      3'd4:    lim = 9'd64;
      3'd5:    lim = 9'd51;
      3'd6:    lim = 9'd42;
      3'd7:    lim = 9'd36;
      default: lim = 9'd256;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== src/sacu_mac.sv =====
// ---------------------------------------------------------------------------
// sacu_mac
// shared multiply-add unit with registered result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacu_mac (
  input  wire logic        clk,
  input  wire logic [9:0]  a,
  input  wire logic [9:0]  b,
  input  wire logic [7:0]  c,
  output logic      [19:0] q
);

  logic [19:0] q_r;
  logic [19:0] q_nxt;

  assign q_nxt = ({10'd0, a} * {10'd0, b}) + {12'd0, c};

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== src/sacu_seq.sv =====
// ---------------------------------------------------------------------------
// sacu_seq
// step sequencer mapping rgb onto the grey ramp or the color cube
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacu_seq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [7:0]              red,
  input  wire logic [7:0]              green,
  input  wire logic [7:0]              blue,
  input  wire sacu_pkg::sacu_cube_cfg_t cfg,
  output sacu_pkg::sacu_seq_res_t       res
);
  import sacu_pkg::*;

  typedef enum logic [6:0] {
    STEP_GREY  = 7'b0000001,
    STEP_RED   = 7'b0000010,
    STEP_GREEN = 7'b0000100,
    STEP_BLUE  = 7'b0001000,
    STEP_RAMP  = 7'b0010000,
    STEP_HORN  = 7'b0100000,
    STEP_DONE  = 7'b1000000
  } step_t;

  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;
  logic [7:0] grey_r, grey_nxt;
  logic       is_grey_r, is_grey_nxt;
  logic [2:0] rr_r, rr_nxt;
  logic [2:0] gg_r, gg_nxt;
  logic [2:0] bb_r, bb_nxt;
  logic [7:0] gidx_r, gidx_nxt;
  logic [7:0] color_r, color_nxt;
  logic       done_r, done_nxt;

  logic [9:0]  mac_a, mac_b;
  logic [7:0]  mac_c;
  logic [19:0] mac_q;

  logic [2:0] cs;
  logic [8:0] lim;
  logic [9:0] sum;
  logic [7:0] grey_w;
  logic [7:0] dr, dg, db;

  sacu_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .q   (mac_q)
  );

  assign cs     = (cfg.cube_levels == 3'd0) ? 3'd1 : cfg.cube_levels;
  assign lim    = grey_limit(cs);
  assign sum    = {2'd0, red} + {2'd0, green} + {2'd0, blue};
  assign grey_w = mac_q[18:11];
  assign dr     = (red   >= grey_w) ? red   - grey_w : grey_w - red;
  assign dg     = (green >= grey_w) ? green - grey_w : grey_w - green;
  assign db     = (blue  >= grey_w) ? blue  - grey_w : grey_w - blue;

  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    grey_nxt    = grey_r;
    is_grey_nxt = is_grey_r;
    rr_nxt      = rr_r;
    gg_nxt      = gg_r;
    bb_nxt      = bb_r;
    gidx_nxt    = gidx_r;
    color_nxt   = color_r;
    done_nxt    = 1'b0;
    mac_a       = '0;
    mac_b       = '0;
    mac_c       = '0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = STEP_GREY;
        mac_a    = sum;
        mac_b    = RECIP3;
      end
    end else begin
      case (step_r)
        STEP_GREY: begin
          step_nxt    = STEP_RED;
          grey_nxt    = grey_w;
          is_grey_nxt = ({1'b0, dr} < lim) && ({1'b0, dg} < lim) && ({1'b0, db} < lim);
          mac_a       = {2'd0, red};
          mac_b       = {7'd0, cs};
        end
        STEP_RED: begin
          step_nxt = STEP_GREEN;
          rr_nxt   = mac_q[10:8];
          mac_a    = {2'd0, green};
          mac_b    = {7'd0, cs};
        end
        STEP_GREEN: begin
          step_nxt = STEP_BLUE;
          gg_nxt   = mac_q[10:8];
          mac_a    = {2'd0, blue};
          mac_b    = {7'd0, cs};
        end
        STEP_BLUE: begin
          step_nxt = STEP_RAMP;
          bb_nxt   = mac_q[10:8];
          mac_a    = {2'd0, grey_r};
          mac_b    = {5'd0, cfg.grey_count};
        end
        STEP_RAMP: begin
          step_nxt = STEP_HORN;
          gidx_nxt = cfg.grey_base + mac_q[15:8];
          mac_a    = {7'd0, rr_r};
          mac_b    = {7'd0, cs};
          mac_c    = {5'd0, gg_r};
        end
        STEP_HORN: begin
          step_nxt = STEP_DONE;
          mac_a    = mac_q[9:0];
          mac_b    = {7'd0, cs};
          mac_c    = {5'd0, bb_r};
        end
        STEP_DONE: begin
          step_nxt  = STEP_GREY;
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
          color_nxt = is_grey_r ? gidx_r : cfg.cube_base + mac_q[7:0];
        end
        default: begin
          step_nxt = STEP_GREY;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_GREY;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grey_r    <= grey_nxt;
    is_grey_r <= is_grey_nxt;
    rr_r      <= rr_nxt;
    gg_r      <= gg_nxt;
    bb_r      <= bb_nxt;
    gidx_r    <= gidx_nxt;
    color_r   <= color_nxt;
  end

  assign res.done  = done_r;
  assign res.color = color_r;

endmodule

`default_nettype wire

// ===== src/sgr_attribute_color_unit_core.sv =====
// ---------------------------------------------------------------------------
// sgr_attribute_color_unit_core
// sgr attribute flags and foreground/background palette tracking
// ---------------------------------------------------------------------------
// One decoded sgr command per item, one result item per command holding the
// palette indices, the five attribute flags and a status. Plain codes and
// palette-index colors go from the accepting edge to commit, and the next
// item is taken as their result shows; 24-bit rgb colors (38;2 and 48;2)
// pass launch, the seven steps of the shared multiply-add unit that finds
// the grey level, the ramp index and the cube coordinates, and capture
// before commit. in_tready is low while an item is at work; a finished
// result waits in the output register while the next item is taken, and
// only that item's commit waits for it. Configuration is to be written only
// while the block is idle, which the block does not enforce; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sgr_attribute_color_unit_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // func, color_format, param_a, param_b, param_c
  input  wire logic [sacu_pkg::IN_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // fg_color, bg_color, bold_on, underline_on, reverse_on, conceal_on,
  // crossed_on, status, one zero pad bit
  output logic      [sacu_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sacu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sacu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sacu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  sacu_cube_cfg_t cube_cfg_r;
  logic [2:0]     def_fg_r;
  logic [7:0]     def_bg_r;

  logic [IN_W-1:0] item_r;
  logic            launch_r, launch_nxt;
  logic [7:0]      col_r, col_nxt;

  logic [2:0] base_r, base_nxt;
  logic       bold_r, bold_nxt;
  logic       uline_r, uline_nxt;
  logic       rev_r, rev_nxt;
  logic       conc_r, conc_nxt;
  logic       cross_r, cross_nxt;
  logic [7:0] fg_r, fg_nxt;
  logic [7:0] bg_r, bg_nxt;
  logic [1:0] stat_w;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;

  sacu_seq_res_t seq_res;

  logic [7:0] func, fmt;
  logic       accept, commit, in_rgb;

  assign func = item_r[7:0];
  assign fmt  = item_r[15:8];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign commit    = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);
  assign in_rgb    = ((in_tdata[7:0] == SGR_FG_EXT) || (in_tdata[7:0] == SGR_BG_EXT))
                     && (in_tdata[15:8] == FMT_RGB);

  sacu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch_r),
    .red   (item_r[23:16]),
    .green (item_r[31:24]),
    .blue  (item_r[39:32]),
    .cfg   (cube_cfg_r),
    .res   (seq_res)
  );

  always_comb begin
    state_nxt  = state_r;
    launch_nxt = 1'b0;
    col_nxt    = col_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = in_rgb ? ST_RUN : ST_COMMIT;
          launch_nxt = in_rgb;
        end
      end
      ST_RUN: begin
        if (seq_res.done) begin
          col_nxt   = seq_res.color;
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    base_nxt  = base_r;
    bold_nxt  = bold_r;
    uline_nxt = uline_r;
    rev_nxt   = rev_r;
    conc_nxt  = conc_r;
    cross_nxt = cross_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    stat_w    = STAT_OK;
    case (func) inside
      [SGR_FG_FIRST:SGR_FG_LAST]: begin
        base_nxt = 3'(func - SGR_FG_FIRST);
        fg_nxt   = {4'd0, bold_r, base_nxt};
      end
      [SGR_BG_FIRST:SGR_BG_LAST]: begin
        bg_nxt = func - SGR_BG_FIRST;
      end
      SGR_RESET: begin
        bold_nxt  = 1'b0;
        uline_nxt = 1'b0;
        rev_nxt   = 1'b0;
        conc_nxt  = 1'b0;
        cross_nxt = 1'b0;
        base_nxt  = def_fg_r;
        fg_nxt    = {5'd0, def_fg_r};
        bg_nxt    = def_bg_r;
      end
      SGR_BOLD: begin
        bold_nxt = 1'b1;
        fg_nxt   = {4'd0, 1'b1, base_r};
      end
      SGR_NO_BOLD: begin
        bold_nxt = 1'b0;
        fg_nxt   = {5'd0, base_r};
      end
      SGR_ULINE:    uline_nxt = 1'b1;
      SGR_REVERSE:  rev_nxt   = 1'b1;
      SGR_CONCEAL:  conc_nxt  = 1'b1;
      SGR_CROSSED:  cross_nxt = 1'b1;
      SGR_NO_ULINE: uline_nxt = 1'b0;
      SGR_NO_REV:   rev_nxt   = 1'b0;
      SGR_NO_CONC:  conc_nxt  = 1'b0;
      SGR_NO_CROSS: cross_nxt = 1'b0;
      SGR_FG_EXT, SGR_BG_EXT: begin
        if ((fmt == FMT_INDEX) || (fmt == FMT_RGB)) begin
          if (func == SGR_FG_EXT) begin
            fg_nxt = (fmt == FMT_INDEX) ? item_r[23:16] : col_r;
          end else begin
            bg_nxt = (fmt == FMT_INDEX) ? item_r[23:16] : col_r;
          end
        end else begin
          stat_w = STAT_BAD_FMT;
        end
      end
      SGR_FG_DEF: begin
        base_nxt = def_fg_r;
        fg_nxt   = {4'd0, bold_r, def_fg_r};
      end
      SGR_BG_DEF: bg_nxt = def_bg_r;
      default:    stat_w = STAT_BAD_CODE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cube_cfg_r  <= '{cube_levels: RST_CUBE_LEVELS, cube_base: RST_CUBE_BASE,
                       grey_count: RST_GREY_COUNT, grey_base: RST_GREY_BASE};
      def_fg_r    <= RST_DEF_FG;
      def_bg_r    <= RST_DEF_BG;
      base_r      <= RST_DEF_FG;
      bold_r      <= 1'b0;
      uline_r     <= 1'b0;
      rev_r       <= 1'b0;
      conc_r      <= 1'b0;
      cross_r     <= 1'b0;
      fg_r        <= {5'd0, RST_DEF_FG};
      bg_r        <= RST_DEF_BG;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUBE_LEVELS: cube_cfg_r.cube_levels <= cfg_data[2:0];
          REG_CUBE_BASE:   cube_cfg_r.cube_base   <= cfg_data;
          REG_GREY_COUNT:  cube_cfg_r.grey_count  <= cfg_data[4:0];
          REG_GREY_BASE:   cube_cfg_r.grey_base   <= cfg_data;
          REG_DEF_FG:      def_fg_r               <= cfg_data[2:0];
          REG_DEF_BG:      def_bg_r               <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        base_r  <= base_nxt;
        bold_r  <= bold_nxt;
        uline_r <= uline_nxt;
        rev_r   <= rev_nxt;
        conc_r  <= conc_nxt;
        cross_r <= cross_nxt;
        fg_r    <= fg_nxt;
        bg_r    <= bg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_tdata;
    end
    col_r <= col_nxt;
    if (commit) begin
      out_data_r <= {1'b0, stat_w, cross_nxt, conc_nxt, rev_nxt, uline_nxt, bold_nxt,
                     bg_nxt, fg_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== src/sacu_checker.sv =====
// ---------------------------------------------------------------------------
// sacu_checker
// port-level checks of the sgr attribute and color unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sacu_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [sacu_pkg::OUT_W-1:0]      out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // no result right after reset
  `SACU_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)
  // not ready in the cycle after an accepted item
  `SACU_ASSERT(a_busy_after_accept, clk, rst_n, in_acc |=> !in_tready)
  // a stalled result holds
  `SACU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // status is never the unused code and the pad bit stays clear
  `SACU_ASSERT(a_status_legal, clk, rst_n, out_tvalid |-> out_tdata[23:21] != 3'b011 && out_tdata[23] == 1'b0)

endmodule

bind sgr_attribute_color_unit_core sacu_checker u_sacu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for sgr_attribute_color_unit_core
// ---------------------------------------------------------------------------
// Drives decoded sgr commands into the stream input and tracks the attribute
// flags and palette indices in a local predictor. Each result item is
// compared field by field against the oldest pending prediction. The
// registers are reprogrammed between idle phases, covering the extremes, the
// masking of wide writes and writes to unused indexes. Both sides idle at
// random, and one phase holds the receiver off long enough to stall the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sacu_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;

  // packed so that the last field, func, lands in the lowest bits
  typedef struct packed {
    logic [7:0] pc;
    logic [7:0] pb;
    logic [7:0] pa;
    logic [7:0] fmt;
    logic [7:0] func;
  } sgr_cmd_t;

  typedef struct packed {
    logic       pad;
    logic [1:0] status;
    logic       crossed;
    logic       conceal;
    logic       reverse;
    logic       uline;
    logic       bold;
    logic [7:0] bg;
    logic [7:0] fg;
  } attr_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sgr_attribute_color_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow registers
  logic [2:0] sh_cube_levels = RST_CUBE_LEVELS;
  logic [7:0] sh_cube_base   = RST_CUBE_BASE;
  logic [4:0] sh_grey_count  = RST_GREY_COUNT;
  logic [7:0] sh_grey_base   = RST_GREY_BASE;
  logic [2:0] sh_def_fg      = RST_DEF_FG;
  logic [7:0] sh_def_bg      = RST_DEF_BG;

  // predicted attribute state
  logic [2:0] base_q    = 3'd7;
  logic       bold_q    = 1'b0;
  logic       uline_q   = 1'b0;
  logic       reverse_q = 1'b0;
  logic       conceal_q = 1'b0;
  logic       crossed_q = 1'b0;
  logic [7:0] fg_q      = 8'd7;
  logic [7:0] bg_q      = 8'd0;

  attr_t pending_attr[$];
  int    mismatches = 0;
  int    stall_count = 0;
  bit    in_gaps = 1'b1;
  bit    out_gaps = 1'b1;
  int    hold_req = 0;
  int    hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned absdiff(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] rgb_palette_index(logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
    int unsigned cs, grey, lim, rr, gg, bb, sum;
    cs   = (sh_cube_levels == 3'd0) ? 1 : int'(sh_cube_levels);
    grey = (int'(r) + int'(g) + int'(b)) / 3;
    lim  = 256 / cs;
    if (absdiff(r, grey) < lim && absdiff(g, grey) < lim && absdiff(b, grey) < lim) begin
      sum = int'(sh_grey_base) + grey * int'(sh_grey_count) / 256;
    end else begin
      rr  = int'(r) * cs / 256;
      gg  = int'(g) * cs / 256;
      bb  = int'(b) * cs / 256;
      sum = int'(sh_cube_base) + rr * cs * cs + gg * cs + bb;
    end
    return sum[7:0];
  endfunction

  function automatic attr_t apply_sgr(sgr_cmd_t c);
    attr_t      r;
    logic [7:0] col;
    logic [1:0] st;
    st  = STAT_OK;
    col = 8'd0;
    if (c.func >= SGR_FG_FIRST && c.func <= SGR_FG_LAST) begin
      base_q = 3'(c.func - SGR_FG_FIRST);
      fg_q   = {4'd0, bold_q, base_q};
    end else if (c.func >= SGR_BG_FIRST && c.func <= SGR_BG_LAST) begin
      bg_q = c.func - SGR_BG_FIRST;
    end else begin
      case (c.func)
        SGR_RESET: begin
          bold_q    = 1'b0;
          uline_q   = 1'b0;
          reverse_q = 1'b0;
          conceal_q = 1'b0;
          crossed_q = 1'b0;
          base_q    = sh_def_fg;
          fg_q      = {4'd0, bold_q, base_q};
          bg_q      = sh_def_bg;
        end
        SGR_BOLD: begin
          bold_q = 1'b1;
          fg_q   = {4'd0, bold_q, base_q};
        end
        SGR_NO_BOLD: begin
          bold_q = 1'b0;
          fg_q   = {4'd0, bold_q, base_q};
        end
        SGR_ULINE:    uline_q   = 1'b1;
        SGR_REVERSE:  reverse_q = 1'b1;
        SGR_CONCEAL:  conceal_q = 1'b1;
        SGR_CROSSED:  crossed_q = 1'b1;
        SGR_NO_ULINE: uline_q   = 1'b0;
        SGR_NO_REV:   reverse_q = 1'b0;
        SGR_NO_CONC:  conceal_q = 1'b0;
        SGR_NO_CROSS: crossed_q = 1'b0;
        SGR_FG_EXT, SGR_BG_EXT: begin
          if (c.fmt == FMT_INDEX) begin
            col = c.pa;
          end else if (c.fmt == FMT_RGB) begin
            col = rgb_palette_index(c.pa, c.pb, c.pc);
          end else begin
            st = STAT_BAD_FMT;
          end
          if (st == STAT_OK) begin
            if (c.func == SGR_FG_EXT) fg_q = col;
            else bg_q = col;
          end
        end
        SGR_FG_DEF: begin
          base_q = sh_def_fg;
          fg_q   = {4'd0, bold_q, base_q};
        end
        SGR_BG_DEF: bg_q = sh_def_bg;
        default:    st = STAT_BAD_CODE;
      endcase
    end
    r.pad     = 1'b0;
    r.status  = st;
    r.crossed = crossed_q;
    r.conceal = conceal_q;
    r.reverse = reverse_q;
    r.uline   = uline_q;
    r.bold    = bold_q;
    r.bg      = bg_q;
    r.fg      = fg_q;
    return r;
  endfunction

  // input side: predict on every accepted command
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_attr.push_back(apply_sgr(sgr_cmd_t'(in_tdata)));
    end
  end

  // register writes update the shadow copy
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CUBE_LEVELS: sh_cube_levels = cfg_data[2:0];
        REG_CUBE_BASE:   sh_cube_base   = cfg_data;
        REG_GREY_COUNT:  sh_grey_count  = cfg_data[4:0];
        REG_GREY_BASE:   sh_grey_base   = cfg_data;
        REG_DEF_FG:      sh_def_fg      = cfg_data[2:0];
        REG_DEF_BG:      sh_def_bg      = cfg_data;
        default: ;
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // output side: compare against the oldest prediction
  always @(posedge clk) begin : result_check
    attr_t want;
    attr_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = attr_t'(out_tdata);
      if (pending_attr.size() == 0) begin
        $display("%0t unexpected result item expected none actual %h", $realtime, out_tdata);
        mismatches++;
      end else begin
        want = pending_attr.pop_front();
        check_field("fg_color", want.fg, got.fg);
        check_field("bg_color", want.bg, got.bg);
        check_field("bold_on", want.bold, got.bold);
        check_field("underline_on", want.uline, got.uline);
        check_field("reverse_on", want.reverse, got.reverse);
        check_field("conceal_on", want.conceal, got.conceal);
        check_field("crossed_on", want.crossed, got.crossed);
        check_field("status", want.status, got.status);
      end
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_gaps && $urandom_range(0, 99) < 33) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog expired, %0d results pending", $realtime,
                 pending_attr.size());
        $display("FAIL sgr_attribute_color_unit_core");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic send_cmd(input logic [7:0] func, input logic [7:0] fmt,
                          input logic [7:0] pa, input logic [7:0] pb,
                          input logic [7:0] pc);
    while (in_gaps && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pc, pb, pa, fmt, func};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_attr.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_palette(input logic [7:0] cs, input logic [7:0] cb,
                             input logic [7:0] gc, input logic [7:0] gb,
                             input logic [7:0] dfg, input logic [7:0] dbg);
    wait_idle();
    cfg_write(REG_CUBE_LEVELS, cs);
    cfg_write(REG_CUBE_BASE, cb);
    cfg_write(REG_GREY_COUNT, gc);
    cfg_write(REG_GREY_BASE, gb);
    cfg_write(REG_DEF_FG, dfg);
    cfg_write(REG_DEF_BG, dbg);
  endtask

  task automatic send_random_cmd();
    logic [7:0] func, fmt, pa, pb, pc, grey;
    int         pick, sel;
    logic [7:0] known[19];
    known = '{SGR_RESET, SGR_BOLD, SGR_ULINE, SGR_REVERSE, SGR_CONCEAL, SGR_CROSSED,
              SGR_NO_BOLD, SGR_NO_ULINE, SGR_NO_REV, SGR_NO_CONC, SGR_NO_CROSS,
              SGR_FG_FIRST, SGR_FG_LAST, SGR_FG_DEF, SGR_BG_FIRST, SGR_BG_LAST,
              SGR_BG_DEF, SGR_FG_EXT, SGR_BG_EXT};
    func = 8'($urandom_range(0, 255));
    fmt  = 8'($urandom_range(0, 255));
    pa   = 8'($urandom_range(0, 255));
    pb   = 8'($urandom_range(0, 255));
    pc   = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      func = $urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT;
      sel  = $urandom_range(0, 9);
      if (sel < 6) fmt = FMT_RGB;
      else if (sel < 9) fmt = FMT_INDEX;
      sel = $urandom_range(0, 2);
      if (sel == 1) begin
        // near-grey colors around the ramp threshold
        grey = 8'($urandom_range(0, 255));
        pa = 8'(($urandom_range(0, 1) ? int'(grey) + $urandom_range(0, 60)
                                      : int'(grey) - $urandom_range(0, 60)));
        pb = 8'(int'(grey) + $urandom_range(0, 20));
        pc = grey;
      end else if (sel == 2) begin
        pa = $urandom_range(0, 1) ? 8'hff : 8'h00;
        pb = $urandom_range(0, 1) ? 8'hff : 8'h00;
        pc = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    end else if (pick < 90) begin
      func = known[$urandom_range(0, 18)];
    end else if (pick < 95) begin
      func = 8'($urandom_range(SGR_FG_FIRST, SGR_BG_LAST));
    end
    send_cmd(func, fmt, pa, pb, pc);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_cmd();
  endtask

  task automatic test_directed();
    send_cmd(SGR_FG_EXT, FMT_RGB, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_BG_EXT, FMT_RGB, 8'd255, 8'd255, 8'd255);
    send_cmd(SGR_FG_EXT, FMT_RGB, 8'd255, 8'd0, 8'd0);
    send_cmd(SGR_BG_EXT, FMT_RGB, 8'd128, 8'd130, 8'd126);
    send_cmd(SGR_FG_EXT, FMT_INDEX, 8'd255, 8'd0, 8'd0);
    send_cmd(SGR_BG_EXT, FMT_INDEX, 8'd0, 8'd255, 8'd255);
    send_cmd(SGR_BOLD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_FG_FIRST, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_FG_LAST, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_NO_BOLD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_ULINE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_REVERSE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_CONCEAL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_CROSSED, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_BG_FIRST, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_BG_LAST, 8'd0, 8'd0, 8'd0, 8'd0);
    // unknown codes and unknown color formats leave the state alone
    send_cmd(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_cmd(8'd2, FMT_INDEX, 8'd9, 8'd0, 8'd0);
    send_cmd(SGR_FG_EXT, 8'd0, 8'd1, 8'd2, 8'd3);
    send_cmd(SGR_BG_EXT, 8'd255, 8'd1, 8'd2, 8'd3);
    send_cmd(SGR_NO_ULINE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_NO_REV, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_NO_CONC, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_NO_CROSS, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_FG_DEF, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_BG_DEF, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cmd(SGR_RESET, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_config_extremes();
    // zero cube levels behave as one
    set_palette(8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd255);
    test_random(220);
    set_palette(8'd7, 8'd255, 8'd31, 8'd255, 8'd7, 8'd0);
    test_random(220);
    set_palette(8'd1, 8'd16, 8'd0, 8'd232, 8'd3, 8'd128);
    test_random(220);
  endtask

  task automatic test_masked_and_ignored_writes();
    // upper data bits are dropped and unused indexes change nothing
    set_palette(8'hfa, 8'h5a, 8'hf8, 8'ha5, 8'hfd, 8'h3c);
    cfg_write(3'd6, 8'hff);
    cfg_write(3'd7, 8'h00);
    cfg_write(3'd7, 8'hff);
    test_random(200);
  endtask

  task automatic test_random_configs();
    repeat (3) begin
      set_palette(8'($urandom_range(1, 6)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(1, 24)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      test_random(170);
    end
  endtask

  task automatic test_no_idle();
    set_palette(8'(RST_CUBE_LEVELS), RST_CUBE_BASE, 8'(RST_GREY_COUNT), RST_GREY_BASE,
                8'(RST_DEF_FG), RST_DEF_BG);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    test_random(250);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    in_gaps  = 1'b0;
    hold_req = HOLD_CYCLES;
    test_random(60);
    in_gaps  = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_config_extremes();
    test_masked_and_ignored_writes();
    test_random_configs();
    test_no_idle();
    test_backpressure();
    wait_idle();
    if (pending_attr.size() == 0 && mismatches == 0) begin
      $display("PASS sgr_attribute_color_unit_core");
    end else begin
      $display("FAIL sgr_attribute_color_unit_core");
    end
    $finish;
  end

endmodule
